>>> rtl/core/pds_pkg.sv
// Shared types and constants for the phase dimmer scheduler.
package pds_pkg;

  localparam int TIMER_W = 16;
  localparam int FRAC_W  = 8;
  localparam int DEV_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 40;

  localparam logic [TIMER_W-1:0] PERIOD_RST = TIMER_W'(10000);
  localparam logic [DEV_W-1:0]   DEV_RST    = DEV_W'(2000);
  localparam logic [FRAC_W-1:0]  ON_RST     = '0;
  localparam logic [FRAC_W-1:0]  OFF_RST    = FRAC_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ON_FRACTION    = 8'd0,
    CFG_OFF_FRACTION   = 8'd1,
    CFG_MAX_DEVIATION  = 8'd2,
    CFG_INITIAL_PERIOD = 8'd3
  } cfg_index_t;

  typedef enum logic {
    OP_SYNC    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_OFF  = 2'd1,
    ACT_ON   = 2'd2
  } action_t;

  // Snapshot of the scheduler state after one beat, handed to the output stage.
  typedef struct packed {
    logic               accepted;
    action_t            act;
    logic [FRAC_W-1:0]  frac;
    logic [TIMER_W-1:0] last_edge;
    logic [TIMER_W-1:0] mean;
    logic               next_cycle;
  } sched_snap_t;

endpackage

>>> rtl/core/phase_dimmer_scheduler_core.sv
// Phase dimmer scheduler: it tracks mains edges from timer timestamps and gives the
// next on/off action with its compare time. One beat is taken every clock cycle
// while the output is not stalled; the state update (edge check and mean filter)
// is registered into the snapshot stage, then the 16x8 fraction product and the
// compare-time sum into the output stage. The mean period always restarts from
// 10000 ticks at reset; a write to initial_period is taken but has no further
// effect, as no register holds it. Configuration writes are taken in every cycle.
module phase_dimmer_scheduler_core
  import pds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] timestamp
  input  logic [0:0]            s_tuser,   // [0] opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] action, [17:2] compare_time,
                                           // [33:18] mean_period, [39:34] zero
  output logic [0:0]            m_tuser,   // [0] sync_accepted
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FRAC_W-1:0]  on_fraction;
  logic [FRAC_W-1:0]  off_fraction;
  logic [DEV_W-1:0]   max_deviation;

  logic [TIMER_W-1:0] last_edge, last_edge_next;
  logic [TIMER_W-1:0] filtered_period, filtered_period_next;
  logic               task_index, task_index_next;
  logic               next_cycle_flag, next_cycle_flag_next;

  logic               in_beat;
  opcode_t            op;
  logic [TIMER_W-1:0] period;
  logic [TIMER_W:0]   thr;
  logic               sync_ok;
  logic [TIMER_W+2:0] mean_sum;
  logic               swap;
  sched_snap_t        snap_next;

  logic               a_valid;
  sched_snap_t        a_snap;
  logic               a_load, o_load;

  logic [TIMER_W+FRAC_W-1:0] prod;
  logic [TIMER_W-1:0]        cmp;

  assign cfg_ready = 1'b1;
  assign in_beat   = s_tvalid && s_tready;
  assign op        = opcode_t'(s_tuser[0]);

  always_comb begin
    period   = s_tdata[TIMER_W-1:0] - last_edge;
    thr      = {1'b0, filtered_period} - {2'b0, max_deviation[DEV_W-1:1]};
    sync_ok  = thr[TIMER_W] || ({1'b0, period} >= thr);
    mean_sum = ({3'b0, filtered_period} << 3) - {3'b0, filtered_period}
             + {3'b0, period} + (TIMER_W+3)'(3);

    last_edge_next       = last_edge;
    filtered_period_next = filtered_period;
    task_index_next      = task_index;
    next_cycle_flag_next = next_cycle_flag;
    snap_next.accepted   = 1'b0;
    unique case (op)
      OP_SYNC: begin
        if (sync_ok) begin
          filtered_period_next = mean_sum[TIMER_W+2:3];
          last_edge_next       = s_tdata[TIMER_W-1:0];
          next_cycle_flag_next = 1'b0;
          snap_next.accepted   = 1'b1;
        end
      end
      OP_ADVANCE: begin
        task_index_next = ~task_index;
        if (task_index) begin
          next_cycle_flag_next = 1'b1;
        end
      end
      default: ;
    endcase

    swap = on_fraction > off_fraction;
    if ((task_index_next == 1'b0) != swap) begin
      snap_next.frac = on_fraction;
      snap_next.act  = ACT_ON;
    end else begin
      snap_next.frac = off_fraction;
      snap_next.act  = ACT_OFF;
    end
    snap_next.last_edge  = last_edge_next;
    snap_next.mean       = filtered_period_next;
    snap_next.next_cycle = next_cycle_flag_next;
  end

  assign o_load   = a_valid && (!m_tvalid || m_tready);
  assign s_tready = !a_valid || o_load;
  assign a_load   = in_beat;

  always_comb begin
    prod = a_snap.mean * a_snap.frac;
    cmp  = a_snap.last_edge + prod[TIMER_W+FRAC_W-1:FRAC_W]
         + (a_snap.next_cycle ? a_snap.mean : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_fraction     <= ON_RST;
      off_fraction    <= OFF_RST;
      max_deviation   <= DEV_RST;
      last_edge       <= '0;
      filtered_period <= PERIOD_RST;
      task_index      <= 1'b0;
      next_cycle_flag <= 1'b0;
      a_valid         <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ON_FRACTION:    on_fraction   <= cfg_data[FRAC_W-1:0];
          CFG_OFF_FRACTION:   off_fraction  <= cfg_data[FRAC_W-1:0];
          CFG_MAX_DEVIATION:  max_deviation <= cfg_data[DEV_W-1:0];
          default: ;
        endcase
      end
      if (in_beat) begin
        last_edge       <= last_edge_next;
        filtered_period <= filtered_period_next;
        task_index      <= task_index_next;
        next_cycle_flag <= next_cycle_flag_next;
      end
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (o_load) begin
        a_valid <= 1'b0;
      end
      if (o_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_snap <= snap_next;
    end
    if (o_load) begin
      m_tdata    <= {6'b0, a_snap.mean, cmp, a_snap.act};
      m_tuser[0] <= a_snap.accepted;
    end
  end

  a_adv_holds_edge: assert property (@(posedge clk) disable iff (rst)
    (in_beat && op == OP_ADVANCE) |=>
      (last_edge == $past(last_edge) && filtered_period == $past(filtered_period)))
    else $error("advance beat changed edge state");

  a_adv_toggles: assert property (@(posedge clk) disable iff (rst)
    (in_beat && op == OP_ADVANCE) |=> (task_index != $past(task_index)))
    else $error("advance beat did not step task index");

  a_sync_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (in_beat && op == OP_SYNC && sync_ok) |=> (!next_cycle_flag && a_snap.accepted))
    else $error("accepted edge did not clear next-cycle flag");

endmodule

>>> tb/phase_dimmer_scheduler_checker.sv
// Checker for the phase dimmer scheduler: predicts every result beat and compares it.
module phase_dimmer_scheduler_checker
  import pds_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] timestamp
  input  logic [0:0]            s_tuser,   // [0] opcode
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,   // [1:0] action, [17:2] compare_time,
                                           // [33:18] mean_period, [39:34] zero
  input  logic [0:0]            m_tuser,   // [0] sync_accepted
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct {
    logic               accepted;
    action_t            act;
    logic [TIMER_W-1:0] cmp;
    logic [TIMER_W-1:0] mean;
  } sched_result_t;

  sched_result_t      due_results[$];

  logic [FRAC_W-1:0]  on_frac;
  logic [FRAC_W-1:0]  off_frac;
  logic [DEV_W-1:0]   max_dev;
  logic [TIMER_W-1:0] last_edge;
  logic [TIMER_W-1:0] mean_period;
  logic               task_idx;
  logic               next_cycle;

  task automatic schedule_item(input opcode_t op, input logic [TIMER_W-1:0] ts);
    sched_result_t      res;
    logic [TIMER_W-1:0] period;
    logic [FRAC_W-1:0]  frac;
    int                 thr;
    logic               on_first;
    res.accepted = 1'b0;
    if (op == OP_SYNC) begin
      period = ts - last_edge;
      thr = int'(mean_period) - int'(max_dev >> 1);
      if (thr < 0 || int'(period) >= thr) begin
        mean_period = TIMER_W'((7 * int'(mean_period) + int'(period) + 3) / 8);
        last_edge = ts;
        next_cycle = 1'b0;
        res.accepted = 1'b1;
      end
    end else begin
      task_idx = ~task_idx;
      if (task_idx == 1'b0) next_cycle = 1'b1;
    end
    // entry 0 holds the earlier fraction; ties put switch-on first
    on_first = (task_idx == 1'b0) != (on_frac > off_frac);
    res.act = on_first ? ACT_ON : ACT_OFF;
    frac = on_first ? on_frac : off_frac;
    res.cmp = TIMER_W'(int'(last_edge) + (int'(mean_period) * int'(frac)) / 256
                       + (next_cycle ? int'(mean_period) : 0));
    res.mean = mean_period;
    due_results.push_back(res);
  endtask

  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst) begin
      on_frac       = ON_RST;
      off_frac      = OFF_RST;
      max_dev       = DEV_RST;
      last_edge     = '0;
      mean_period   = PERIOD_RST;
      task_idx      = 1'b0;
      next_cycle    = 1'b0;
      due_results.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ON_FRACTION:   on_frac  = cfg_data[FRAC_W-1:0];
          CFG_OFF_FRACTION:  off_frac = cfg_data[FRAC_W-1:0];
          CFG_MAX_DEVIATION: max_dev  = cfg_data[DEV_W-1:0];
          // initial_period has no effect: reset restores the fixed reset period
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) schedule_item(opcode_t'(s_tuser[0]), s_tdata[TIMER_W-1:0]);
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("result beat with nothing pending");
          fail_count++;
        end else begin
          exp_res = due_results.pop_front();
          if (m_tuser[0] !== exp_res.accepted) begin
            $error("sync_accepted: expected %0d, got %0d", exp_res.accepted, m_tuser[0]);
            fail_count++;
          end
          if (m_tdata[1:0] !== exp_res.act) begin
            $error("action: expected %0d, got %0d", exp_res.act, m_tdata[1:0]);
            fail_count++;
          end
          if (m_tdata[17:2] !== exp_res.cmp) begin
            $error("compare_time: expected %0d, got %0d", exp_res.cmp, m_tdata[17:2]);
            fail_count++;
          end
          if (m_tdata[33:18] !== exp_res.mean) begin
            $error("mean_period: expected %0d, got %0d", exp_res.mean, m_tdata[33:18]);
            fail_count++;
          end
          if (m_tdata[39:34] !== '0) begin
            $error("padding: expected 0, got %0d", m_tdata[39:34]);
            fail_count++;
          end
        end
      end
      pending_count = due_results.size();
    end
  end

endmodule

>>> tb/phase_dimmer_scheduler_core_tb.sv
// Testbench top for the phase dimmer scheduler: stimulus, watchdog and verdict.
module phase_dimmer_scheduler_core_tb;
  import pds_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 8'hFF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 255;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  calm = 1'b0;
  int                    fail_count;
  int                    pending_count;
  int                    idle_cycles = 0;

  phase_dimmer_scheduler_core i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  phase_dimmer_scheduler_checker i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Enter and leave at a falling edge; valid stays high for the next beat.
  task automatic send_item(input opcode_t op, input logic [TIMER_W-1:0] ts);
    while (!calm && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= ts;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] on_f, input logic [7:0] off_f,
                           input logic [15:0] dev, input logic [15:0] init_p,
                           input bit with_unused);
    cfg_beat(CFG_ON_FRACTION, {8'($urandom), on_f});
    cfg_beat(CFG_OFF_FRACTION, {8'($urandom), off_f});
    cfg_beat(CFG_MAX_DEVIATION, dev);
    cfg_beat(CFG_INITIAL_PERIOD, init_p);
    if (with_unused) cfg_beat(CFG_IDX_NONE, 16'hFFFF);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly well-formed mains cycles: one edge near the nominal period, then on and off.
  task automatic run_random(input int n_items, input int nominal);
    int                 sent;
    int                 r;
    int                 jitter;
    logic [TIMER_W-1:0] edge_ts;
    sent = 0;
    edge_ts = TIMER_W'($urandom);
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 75) begin
        jitter = int'($urandom_range(nominal / 4)) - nominal / 8;
        edge_ts = edge_ts + TIMER_W'(nominal + jitter);
        send_item(OP_SYNC, edge_ts);
        send_item(OP_ADVANCE, TIMER_W'($urandom));
        send_item(OP_ADVANCE, TIMER_W'($urandom));
        sent += 3;
      end else if (r < 90) begin
        send_item(OP_SYNC, TIMER_W'($urandom));
        sent++;
      end else begin
        send_item(OP_ADVANCE, TIMER_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int nominal;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset settings: threshold edges, timer wrap, advances with next-cycle flag
    send_item(OP_ADVANCE, 16'hFFFF);
    send_item(OP_ADVANCE, 16'h0000);
    send_item(OP_ADVANCE, 16'hAAAA);
    send_item(OP_SYNC, 16'd8999);
    send_item(OP_SYNC, 16'd9000);
    send_item(OP_SYNC, 16'd17874);
    send_item(OP_SYNC, 16'd17875);
    send_item(OP_ADVANCE, 16'h5555);
    send_item(OP_SYNC, 16'hFFFF);
    send_item(OP_SYNC, 16'd13488);
    send_item(OP_ADVANCE, 16'h0000);
    send_item(OP_SYNC, 16'h0000);
    drain();

    // swapped table, threshold below zero, unused register index
    configure(8'd255, 8'd0, 16'hFFFF, 16'h0000, 1'b1);
    send_item(OP_SYNC, 16'd1);
    send_item(OP_SYNC, 16'd2);
    send_item(OP_ADVANCE, 16'd0);
    send_item(OP_SYNC, 16'h5555);
    send_item(OP_ADVANCE, 16'd0);
    send_item(OP_ADVANCE, 16'd0);
    drain();

    // equal fractions, zero deviation
    configure(8'd128, 8'd128, 16'h0000, 16'hFFFF, 1'b0);
    send_item(OP_SYNC, 16'h8000);
    send_item(OP_ADVANCE, 16'd0);
    send_item(OP_SYNC, 16'h8000);
    send_item(OP_ADVANCE, 16'd0);
    send_item(OP_SYNC, 16'hC000);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      nominal = $urandom_range(200, 60000);
      case (ph)
        0: configure(8'd0, 8'd255, 16'h0000, 16'($urandom), 1'b0);
        1: configure(8'd255, 8'd0, 16'hFFFF, 16'($urandom), 1'b0);
        default: configure(8'($urandom), 8'($urandom), 16'($urandom_range(nominal / 8, nominal)),
                           16'($urandom), 1'b0);
      endcase
      calm <= (ph == 2);
      run_random(PHASE_ITEMS, nominal);
      drain();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
